FILE: rtl/dsh_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsh_pkg
// Shared constants and the command type of the diamond-square heightmap core.
// ----------------------------------------------------------------------------
package dsh_pkg;

  // grid geometry
  localparam int GRID_LOG2 = 3;
  localparam int GRID_W    = (1 << GRID_LOG2) + 1;
  localparam int GRID_N    = GRID_W * GRID_W;
  localparam int CRD_W     = GRID_LOG2 + 1;
  localparam int CRD_NW    = CRD_W + 1;
  localparam int ADDR_W    = $clog2(GRID_N);
  localparam int INDEX_W   = 7;

  // payload widths
  localparam int SAMPLE_W  = 10;
  localparam int AMP_W     = 12;
  localparam int HEIGHT_W  = 20;
  localparam int FRAC_W    = 8;
  localparam logic [AMP_W-1:0] AMP_RESET = AMP_W'(256);

  // offset = round(sample * amplitude) back to 8 fraction bits
  localparam int PROD_W    = SAMPLE_W + AMP_W + 1;
  localparam int OFF_W     = PROD_W - FRAC_W;

  // neighbour sum and divide-by-three by reciprocal
  localparam int SUM_W     = HEIGHT_W + 2;
  localparam int W3_W      = SUM_W + 2;
  localparam int DIV3_K    = SUM_W + 3;
  localparam int DIV3_M_W  = DIV3_K - 1;
  localparam logic [DIV3_M_W-1:0] DIV3_M = DIV3_M_W'(((1 << DIV3_K) + 2) / 3);

  // reads per point, queue geometry
  localparam int N_RD      = 4;
  localparam int RD_CW     = $clog2(N_RD);
  localparam int Q_DEPTH   = 4;
  localparam int Q_AW      = $clog2(Q_DEPTH);

  typedef struct packed {
    logic [N_RD-1:0][ADDR_W-1:0] rd_addr;
    logic [N_RD-1:0]             rd_use;
    logic                        cnt3;
    logic [ADDR_W-1:0]           wr_addr;
    logic [INDEX_W-1:0]          pidx;
    logic signed [OFF_W-1:0]     offset;
    logic                        last;
  } cmd_t;

endpackage

FILE: rtl/dsh_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsh_front
// Visiting-order sequencer: takes one sample per beat, works out the target
// point, its neighbour addresses and the scaled offset, and queues a command.
// ----------------------------------------------------------------------------
module dsh_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic [dsh_pkg::AMP_W-1:0]     cfg_wr_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [dsh_pkg::SAMPLE_W-1:0] random_sample,
  input  logic                          q_full,
  output logic                          push,
  output dsh_pkg::cmd_t                 push_cmd
);
  import dsh_pkg::*;

  typedef enum logic [2:0] {
    PH_CORNER  = 3'b001,
    PH_DIAMOND = 3'b010,
    PH_SQUARE  = 3'b100
  } phase_t;

  localparam int N_CORNER = 4;
  localparam logic [CRD_W-1:0]  C_LAST = CRD_W'(GRID_W - 1);
  localparam logic [CRD_NW-1:0] W_LAST = CRD_NW'(GRID_W - 1);
  localparam logic [CRD_NW-1:0] W_GRID = CRD_NW'(GRID_W);
  localparam logic signed [PROD_W-1:0] RND = PROD_W'(1 << (FRAC_W - 1));

  phase_t             phase, phase_next;
  logic [CRD_W-1:0]   step, step_next;
  logic [CRD_W-1:0]   cx, cx_next;
  logic [CRD_W-1:0]   cy, cy_next;
  logic [AMP_W-1:0]   amp, amp_next;
  logic [AMP_W-1:0]   init_amp;

  logic [CRD_W-1:0]   hs;
  logic [CRD_NW-1:0]  s_w, hs_w, cx_w, cy_w;
  logic [CRD_NW-1:0]  cy_s, cx_s, cx_h, cy_wrap;
  logic [AMP_W-1:0]   amp_use;
  logic signed [PROD_W-1:0] prod, prod_rnd;
  logic signed [OFF_W-1:0]  off;
  logic               neg;
  logic               done;
  logic [CRD_W-1:0]   px, py;
  logic [CRD_W-1:0]   rx [N_RD];
  logic [CRD_W-1:0]   ry [N_RD];
  logic [N_RD-1:0]    use_rd;
  logic [31:0]        pos_w;
  logic [31:0]        pos_r [N_RD];

  function automatic logic [31:0] pt_pos(input logic [CRD_W-1:0] x,
                                         input logic [CRD_W-1:0] y);
    return 32'(x) + 32'(y) * 32'(GRID_W);
  endfunction

  assign hs   = step >> 1;
  assign s_w  = CRD_NW'(step);
  assign hs_w = CRD_NW'(hs);
  assign cx_w = CRD_NW'(cx);
  assign cy_w = CRD_NW'(cy);
  assign cy_s = cy_w + s_w;
  assign cx_s = cx_w + s_w;
  assign cx_h = cx_w + hs_w;
  assign cy_wrap = (cx_h + hs_w) & (s_w - CRD_NW'(1));

  // no beat is taken while in reset
  assign in_stall = q_full || rst;
  assign push     = in_valid && !in_stall;

  // first corner of a map restarts the amplitude
  assign amp_use  = (phase == PH_CORNER && cx == '0) ? init_amp : amp;
  assign prod     = PROD_W'(random_sample) * PROD_W'($signed({1'b0, amp_use}));
  assign prod_rnd = prod + RND;
  assign off      = OFF_W'(prod_rnd >>> FRAC_W);

  // target point and neighbours
  always_comb begin
    px     = '0;
    py     = '0;
    neg    = 1'b0;
    use_rd = '0;
    for (int k = 0; k < N_RD; k++) begin
      rx[k] = '0;
      ry[k] = '0;
    end
    unique case (phase)
      PH_DIAMOND: begin
        px     = CRD_W'(cx_h);
        py     = CRD_W'(cy_w + hs_w);
        rx[0]  = cx;              ry[0] = cy;
        rx[1]  = CRD_W'(cx_s);    ry[1] = cy;
        rx[2]  = cx;              ry[2] = CRD_W'(cy_s);
        rx[3]  = CRD_W'(cx_s);    ry[3] = CRD_W'(cy_s);
        use_rd = '1;
      end
      PH_SQUARE: begin
        px        = cx;
        py        = cy;
        rx[0]     = CRD_W'(cx_w - hs_w);  ry[0] = cy;
        use_rd[0] = (cx >= hs);
        rx[1]     = cx;                   ry[1] = CRD_W'(cy_w + hs_w);
        use_rd[1] = ((cy_w + hs_w) < W_GRID);
        rx[2]     = CRD_W'(cx_h);         ry[2] = cy;
        use_rd[2] = (cx_h < W_GRID);
        rx[3]     = cx;                   ry[3] = CRD_W'(cy_w - hs_w);
        use_rd[3] = (cy >= hs);
      end
      default: begin
        px  = cx[0] ? C_LAST : '0;
        py  = cx[1] ? C_LAST : '0;
        neg = (cx == CRD_W'(1)) || (cx == CRD_W'(2));
      end
    endcase
  end

  // sequencer advance
  always_comb begin
    phase_next = phase;
    step_next  = step;
    cx_next    = cx;
    cy_next    = cy;
    amp_next   = amp;
    done       = 1'b0;
    unique case (phase)
      PH_DIAMOND: begin
        if (cy_s >= W_LAST) begin
          cy_next = '0;
          if (cx_s >= W_LAST) begin
            phase_next = PH_SQUARE;
            cx_next    = '0;
            cy_next    = hs;
          end else begin
            cx_next = CRD_W'(cx_s);
          end
        end else begin
          cy_next = CRD_W'(cy_s);
        end
      end
      PH_SQUARE: begin
        if (cy_s >= W_GRID) begin
          if (cx_h >= W_GRID) begin
            // level finished
            step_next = hs;
            amp_next  = amp >> 1;
            cx_next   = '0;
            cy_next   = '0;
            if (hs > CRD_W'(1)) begin
              phase_next = PH_DIAMOND;
            end else begin
              phase_next = PH_CORNER;
              done       = 1'b1;
            end
          end else begin
            cx_next = CRD_W'(cx_h);
            cy_next = CRD_W'(cy_wrap);
          end
        end else begin
          cy_next = CRD_W'(cy_s);
        end
      end
      default: begin
        if (cx == '0) begin
          amp_next  = init_amp;
          step_next = C_LAST;
        end
        cx_next = cx + CRD_W'(1);
        if (cx == CRD_W'(N_CORNER - 1)) begin
          phase_next = PH_DIAMOND;
          cx_next    = '0;
          cy_next    = '0;
        end
      end
    endcase
  end

  // command assembly
  always_comb begin
    pos_w            = pt_pos(px, py);
    push_cmd.wr_addr = pos_w[ADDR_W-1:0];
    push_cmd.pidx    = pos_w[INDEX_W-1:0];
    for (int k = 0; k < N_RD; k++) begin
      pos_r[k]            = pt_pos(rx[k], ry[k]);
      push_cmd.rd_addr[k] = use_rd[k] ? pos_r[k][ADDR_W-1:0] : '0;
    end
    push_cmd.rd_use = use_rd;
    push_cmd.cnt3   = (phase == PH_SQUARE) && !(&use_rd);
    push_cmd.offset = neg ? -off : off;
    push_cmd.last   = done;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_CORNER;
      step     <= C_LAST;
      cx       <= '0;
      cy       <= '0;
      amp      <= AMP_RESET;
      init_amp <= AMP_RESET;
    end else begin
      if (cfg_wr_en) begin
        init_amp <= cfg_wr_data;
      end
      if (push) begin
        phase <= phase_next;
        step  <= step_next;
        cx    <= cx_next;
        cy    <= cy_next;
        amp   <= amp_next;
      end
    end
  end

endmodule

FILE: rtl/dsh_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsh_queue
// Small command FIFO between the sequencer and the height datapath.
// ----------------------------------------------------------------------------
module dsh_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  dsh_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output dsh_pkg::cmd_t head,
  output logic          nempty
);
  import dsh_pkg::*;

  cmd_t            slots [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr;
  logic [Q_AW-1:0] rd_ptr;
  logic [Q_AW:0]   count;

  assign full   = (count == (Q_AW + 1)'(Q_DEPTH));
  assign nempty = (count != '0);
  assign head   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + Q_AW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + Q_AW'(1);
      end
      if (push && !pop) begin
        count <= count + (Q_AW + 1)'(1);
      end else if (pop && !push) begin
        count <= count - (Q_AW + 1)'(1);
      end
    end
  end

endmodule

FILE: rtl/dsh_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsh_back
// Height datapath: reads the neighbours from the height store one per cycle
// while no hazard or busy tail holds it, sums them, takes the rounded mean,
// adds the offset, saturates, writes the store and presents the result beat.
// ----------------------------------------------------------------------------
module dsh_back (
  input  logic                          clk,
  input  logic                          rst,
  input  dsh_pkg::cmd_t                 head,
  input  logic                          q_nempty,
  output logic                          pop,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [dsh_pkg::INDEX_W-1:0]   point_index,
  output logic signed [dsh_pkg::HEIGHT_W-1:0] height,
  output logic                          last_point
);
  import dsh_pkg::*;

  typedef enum logic [2:0] {
    B_IDLE = 3'b001,
    B_DIV  = 3'b010,
    B_FIN  = 3'b100
  } tail_state_t;

  localparam int PRD3_W = W3_W + DIV3_M_W;
  localparam logic [W3_W-1:0] W3_BIAS = W3_W'(1 + 3 * (1 << (SUM_W - 1)));
  localparam logic signed [SUM_W:0] TOT_MAX = (SUM_W + 1)'((1 << (HEIGHT_W - 1)) - 1);
  localparam logic signed [SUM_W:0] TOT_MIN = (SUM_W + 1)'(-(1 << (HEIGHT_W - 1)));

  logic signed [HEIGHT_W-1:0] mem [GRID_N];

  // read issue and accumulate
  logic [RD_CW-1:0]           k;
  logic                       issue;
  logic                       hazard;
  logic                       freeze;
  logic                       handoff;
  logic signed [HEIGHT_W-1:0] rd_data;
  logic                       p_vld, p_first, p_last, p_use;
  cmd_t                       p_cmd;
  logic signed [SUM_W-1:0]    acc;
  logic signed [SUM_W-1:0]    d;
  logic signed [SUM_W-1:0]    acc_sum;

  // mean, offset and write-back
  tail_state_t                b_state, b_state_next;
  logic                       b_ready;
  cmd_t                       b_cmd;
  logic signed [SUM_W-1:0]    b_sum;
  logic [PRD3_W-1:0]          b_prod;
  logic signed [SUM_W-1:0]    b_mean4;
  logic [W3_W-1:0]            w3;
  logic [PRD3_W-1:0]          prod3;
  logic signed [SUM_W-1:0]    mean4;
  logic [SUM_W-1:0]           q3;
  logic signed [SUM_W-1:0]    mean3;
  logic signed [SUM_W-1:0]    mean;
  logic signed [SUM_W:0]      tot;
  logic signed [HEIGHT_W-1:0] hsat;
  logic                       out_free;
  logic                       fin_go;

  assign b_ready = (b_state == B_IDLE);
  assign freeze  = p_vld && p_last && !b_ready;
  assign handoff = p_vld && p_last && b_ready;

  // a point may not read a height that is still on its way to the store
  always_comb begin
    hazard = 1'b0;
    for (int j = 0; j < N_RD; j++) begin
      if (head.rd_use[j] &&
          ((p_vld && p_last && head.rd_addr[j] == p_cmd.wr_addr) ||
           (!b_ready && head.rd_addr[j] == b_cmd.wr_addr))) begin
        hazard = 1'b1;
      end
    end
  end

  assign issue   = q_nempty && !freeze && !(k == '0 && hazard);
  assign pop     = issue && (k == RD_CW'(N_RD - 1));
  assign d       = p_use ? SUM_W'(rd_data) : '0;
  assign acc_sum = (p_first ? '0 : acc) + d;

  // mean of four: floor((sum + 2) / 4); mean of three via biased reciprocal
  assign mean4 = (b_sum + SUM_W'(2)) >>> 2;
  assign w3    = W3_W'(b_sum) + W3_BIAS;
  assign prod3 = PRD3_W'(w3) * PRD3_W'(DIV3_M);
  assign q3    = b_prod[DIV3_K +: SUM_W];
  assign mean3 = $signed({~q3[SUM_W-1], q3[SUM_W-2:0]});
  assign mean  = b_cmd.cnt3 ? mean3 : b_mean4;
  assign tot   = (SUM_W + 1)'(mean) + (SUM_W + 1)'($signed(b_cmd.offset));

  always_comb begin
    if (tot > TOT_MAX) begin
      hsat = HEIGHT_W'(TOT_MAX);
    end else if (tot < TOT_MIN) begin
      hsat = HEIGHT_W'(TOT_MIN);
    end else begin
      hsat = tot[HEIGHT_W-1:0];
    end
  end

  assign out_free = !out_valid || !out_stall;
  assign fin_go   = (b_state == B_FIN) && out_free;

  always_comb begin
    b_state_next = b_state;
    unique case (b_state)
      B_IDLE:  if (handoff) b_state_next = B_DIV;
      B_DIV:   b_state_next = B_FIN;
      B_FIN:   if (fin_go) b_state_next = B_IDLE;
      default: b_state_next = B_IDLE;
    endcase
  end

  // height store: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (fin_go) begin
      mem[b_cmd.wr_addr] <= hsat;
    end
    if (issue) begin
      rd_data <= mem[head.rd_addr[k]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      k       <= '0;
      p_vld   <= 1'b0;
      b_state <= B_IDLE;
    end else begin
      if (issue) begin
        k <= k + RD_CW'(1);
      end
      if (!freeze) begin
        p_vld <= issue;
      end
      b_state <= b_state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (!freeze) begin
      p_first <= (k == '0);
      p_last  <= (k == RD_CW'(N_RD - 1));
      p_use   <= head.rd_use[k];
    end
    if (pop) begin
      p_cmd <= head;
    end
    if (p_vld && !p_last) begin
      acc <= acc_sum;
    end
    if (handoff) begin
      b_sum <= acc_sum;
      b_cmd <= p_cmd;
    end
    if (b_state == B_DIV) begin
      b_prod  <= prod3;
      b_mean4 <= mean4;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fin_go) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_go) begin
      point_index <= b_cmd.pidx;
      height      <= hsat;
      last_point  <= b_cmd.last;
    end
  end

endmodule

FILE: rtl/diamond_square_heightmap_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// diamond_square_heightmap_core
// Diamond-square heightmap generator on a 9 x 9 grid.
//
// Input beat: one signed random sample (Q2.8) on in_valid / in_stall. Each
// sample produces exactly one output beat with the index of the grid point
// written, its saturated Q12.8 height and last_point on the final point of a
// map; the sample after that starts a new map with the four corners.
// cfg_wr_en / cfg_wr_data set the starting amplitude (Q4.8, 256 after reset),
// picked up at the first corner of the next map.
// Each point spends four neighbour reads on the single read port of the
// height store. A point that reads a height still on its way to the store
// waits for that write.
// The sequencer accepts into a 4-deep command queue, so inputs are taken back
// to back until the queue fills. While out_valid and out_stall are both high
// the result register holds, the datapath stops behind it and the queue then
// stalls the input. Reset (rst, synchronous) empties the queue and pipeline
// and returns to the first corner; the height store is not cleared, the
// visiting order reads only points written earlier in the same map.
// ----------------------------------------------------------------------------
module diamond_square_heightmap_core (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_wr_en,
  input  logic [dsh_pkg::AMP_W-1:0]            cfg_wr_data,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [dsh_pkg::SAMPLE_W-1:0]  random_sample,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [dsh_pkg::INDEX_W-1:0]          point_index,
  output logic signed [dsh_pkg::HEIGHT_W-1:0]  height,
  output logic                                 last_point
);
  import dsh_pkg::*;

  logic push;
  cmd_t push_cmd;
  logic q_full;
  logic q_pop;
  logic q_nempty;
  cmd_t q_head;

  dsh_front u_front (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .random_sample (random_sample),
    .q_full        (q_full),
    .push          (push),
    .push_cmd      (push_cmd)
  );

  dsh_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .head     (q_head),
    .nempty   (q_nempty)
  );

  dsh_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (q_head),
    .q_nempty    (q_nempty),
    .pop         (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .point_index (point_index),
    .height      (height),
    .last_point  (last_point)
  );

  // datapath only consumes commands that are there
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_nempty)
    else $error("command popped from an empty queue");

  // corners read nothing, diamonds four, squares three or four
  a_read_count: assert property (@(posedge clk) disable iff (rst)
    push |-> ($countones(push_cmd.rd_use) != 1 && $countones(push_cmd.rd_use) != 2))
    else $error("point queued with one or two neighbour reads");

  a_cnt3_match: assert property (@(posedge clk) disable iff (rst)
    (push && push_cmd.cnt3) |-> ($countones(push_cmd.rd_use) == 3))
    else $error("three-neighbour mean flagged with wrong read mask");

  // the final point of a map is a square point on the grid edge
  a_last_edge: assert property (@(posedge clk) disable iff (rst)
    (push && push_cmd.last) |-> push_cmd.cnt3)
    else $error("last point of map is not an edge square point");

endmodule
